[hdl/scrgb_pkg.sv]
package scrgb_pkg;

    localparam int DATA_W    = 32;
    localparam int CFG_IDX_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_HIGH = 2'd1;

    // control bits that travel with every item
    typedef struct packed {
        logic valid;
        logic has;
    } t_ctl;

endpackage

[hdl/scalar_to_rainbow_rgb_unit.sv]
// Rainbow color map of a scalar pixel stream.
// Items pass through the prep, divider and color pipelines in turn; the
// pipelined restoring divider, one quotient bit per stage, holds most of the stages.
// Throughput: one item per clock; busy stays low and the receiver cannot stall.
// Reset (i_rst_n low at a clock edge) clears all valid bits and sets range_low to 0
// and range_high to 1.0 in Q16.16.
module scalar_to_rainbow_rgb_unit import scrgb_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // item channel
    input  logic                     start,
    output logic                     busy,
    input  logic signed [DATA_W-1:0] i_scalar_value,
    input  logic                     i_has_value,
    // result channel
    output logic                     o_valid,
    output logic [7:0]               o_red,
    output logic [7:0]               o_green,
    output logic [7:0]               o_blue,
    // configuration write channel
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [DATA_W-1:0]        i_cfg_data
);

    localparam int LAT = FRAC_BITS + 10;
    localparam logic signed [DATA_W-1:0] RANGE_HIGH_RST = 32'sd65536;

    logic signed [DATA_W-1:0] r_range_low;
    logic signed [DATA_W-1:0] r_range_high;

    t_ctl               in_ctl;
    t_ctl               prep_ctl;
    t_ctl               div_ctl;
    logic [DATA_W-1:0]  prep_num;
    logic [DATA_W-1:0]  prep_den;
    logic [FRAC_BITS:0] div_q;

    // every stage advances every cycle, so take an item whenever offered
    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    // configuration registers; writes to unknown indexes drop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_low  <= '0;
            r_range_high <= RANGE_HIGH_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_RANGE_LOW:  r_range_low  <= i_cfg_data;
                CFG_RANGE_HIGH: r_range_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign in_ctl = '{valid: start && !busy, has: i_has_value};

    // clamp to the range and form numerator and span (2 stages)
    scrgb_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (in_ctl),
        .i_x     (i_scalar_value),
        .i_lo    (r_range_low),
        .i_hi    (r_range_high),
        .o_ctl   (prep_ctl),
        .o_num   (prep_num),
        .o_den   (prep_den)
    );

    // scale to v = num/den in Q1.FRAC_BITS (FRAC_BITS+1 stages)
    scrgb_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (prep_ctl),
        .i_num   (prep_num),
        .i_den   (prep_den),
        .o_ctl   (div_ctl),
        .o_q     (div_q)
    );

    // hue, lightness and sector select down to bytes (7 stages)
    scrgb_color #(
        .FRAC_BITS (FRAC_BITS)
    ) u_color (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (div_ctl),
        .i_q     (div_q),
        .o_valid (o_valid),
        .o_red   (o_red),
        .o_green (o_green),
        .o_blue  (o_blue)
    );

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LAT))
        else $error("result without an accepted item");

    a_no_loss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_valid)
        else $error("accepted item produced no result");

    a_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !$past(i_has_value, LAT)) |->
        (o_red == 8'd0 && o_green == 8'd0 && o_blue == 8'd0))
        else $error("pixel without value is not black");

endmodule

[hdl/scrgb_prep.sv]
module scrgb_prep import scrgb_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_ctl                     i_ctl,
    input  logic signed [DATA_W-1:0] i_x,
    input  logic signed [DATA_W-1:0] i_lo,
    input  logic signed [DATA_W-1:0] i_hi,
    output t_ctl                     o_ctl,
    output logic [DATA_W-1:0]        o_num,
    output logic [DATA_W-1:0]        o_den
);

    t_ctl                     r1_ctl;
    logic signed [DATA_W-1:0] r1_x;
    logic signed [DATA_W-1:0] r1_lo;
    logic signed [DATA_W-1:0] r1_hi;
    logic                     r1_gt;
    logic                     r1_lt;
    logic                     r1_empty;
    logic [DATA_W-1:0]        r1_den;

    t_ctl                     r2_ctl;
    logic [DATA_W-1:0]        r2_num;
    logic [DATA_W-1:0]        r2_den;

    logic signed [DATA_W-1:0] xcl;
    logic [DATA_W-1:0]        n_num;
    logic [DATA_W-1:0]        n_den;

    // stage 1: range compares and span
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_ctl <= '0;
        end else begin
            r1_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_x     <= i_x;
        r1_lo    <= i_lo;
        r1_hi    <= i_hi;
        r1_gt    <= i_x > i_hi;
        r1_lt    <= i_x < i_lo;
        r1_empty <= i_hi <= i_lo;
        r1_den   <= DATA_W'(i_hi - i_lo);
    end

    // stage 2: clamp and offset; an empty range divides zero by one
    always_comb begin
        if (r1_gt) begin
            xcl = r1_hi;
        end else if (r1_lt) begin
            xcl = r1_lo;
        end else begin
            xcl = r1_x;
        end
        n_num = r1_empty ? '0 : DATA_W'(xcl - r1_lo);
        n_den = r1_empty ? DATA_W'(1) : r1_den;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_ctl <= '0;
        end else begin
            r2_ctl <= r1_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_num <= n_num;
        r2_den <= n_den;
    end

    assign o_ctl = r2_ctl;
    assign o_num = r2_num;
    assign o_den = r2_den;

endmodule

[hdl/scrgb_div.sv]
module scrgb_div import scrgb_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_ctl                i_ctl,
    input  logic [DATA_W-1:0]   i_num,
    input  logic [DATA_W-1:0]   i_den,
    output t_ctl                o_ctl,
    output logic [FRAC_BITS:0]  o_q
);

    localparam int NS = FRAC_BITS + 1;
    localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

    t_ctl               r_ctl [NS];
    logic [DATA_W-1:0]  r_rem [NS];
    logic [DATA_W-1:0]  r_den [NS];
    logic [FRAC_BITS:0] r_q   [NS];

    // one quotient bit per stage, most significant first; num <= den so
    // the first stage settles the integer bit
    for (genvar k = 0; k < NS; k++) begin : g_stage
        logic [DATA_W:0]    cand;
        logic [DATA_W:0]    diff;
        logic [DATA_W-1:0]  pden;
        logic [FRAC_BITS:0] pq;
        t_ctl               pctl;
        logic               ge;

        if (k == 0) begin : g_first
            assign cand = {1'b0, i_num};
            assign pden = i_den;
            assign pq   = '0;
            assign pctl = i_ctl;
        end else begin : g_next
            assign cand = {r_rem[k-1], 1'b0};
            assign pden = r_den[k-1];
            assign pq   = r_q[k-1];
            assign pctl = r_ctl[k-1];
        end

        assign ge   = cand >= {1'b0, pden};
        assign diff = cand - {1'b0, pden};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl[k] <= '0;
            end else begin
                r_ctl[k] <= pctl;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[k] <= ge ? diff[DATA_W-1:0] : cand[DATA_W-1:0];
            r_den[k] <= pden;
            r_q[k]   <= {pq[FRAC_BITS-1:0], ge};
        end
    end

    assign o_ctl = r_ctl[NS-1];
    assign o_q   = r_q[NS-1];

    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ctl[0].valid |-> r_rem[0] < r_den[0])
        else $error("divider remainder not below divisor");

    a_q_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ctl[NS-1].valid |-> r_q[NS-1] <= ONE)
        else $error("scaled value above one");

endmodule

[hdl/scrgb_color.sv]
module scrgb_color import scrgb_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_ctl               i_ctl,
    input  logic [FRAC_BITS:0] i_q,
    output logic               o_valid,
    output logic [7:0]         o_red,
    output logic [7:0]         o_green,
    output logic [7:0]         o_blue
);

    localparam int F   = FRAC_BITS;
    localparam int VW  = F + 1;     // fraction 0..ONE
    localparam int TW  = F + 6;     // 62*w
    localparam int HPW = F + 3;     // hue/60
    localparam int UW  = F + 3;     // 7*w^4
    localparam int HUE_DIV = 15;    // 248/60 reduced to 62/15
    localparam int LIT_DIV = 25;    // 28/100 reduced to 7/25
    localparam logic [VW-1:0]  ONE  = {1'b1, {F{1'b0}}};
    localparam logic [F-1:0]   HALF = {1'b1, {(F-1){1'b0}}};
    localparam logic [HPW-1:0] HUE_RECIP = HPW'((64'd1 << TW) / HUE_DIV);
    localparam logic [F-1:0]   LIT_RECIP = F'((64'd1 << UW) / LIT_DIV);
    localparam logic [HPW-1:0] HP_LIMIT  = HPW'(5) << F;

    localparam logic [2:0] SEC_RY = 3'd0;
    localparam logic [2:0] SEC_YG = 3'd1;
    localparam logic [2:0] SEC_GC = 3'd2;
    localparam logic [2:0] SEC_CB = 3'd3;
    localparam logic [2:0] SEC_BM = 3'd4;
    localparam logic [2:0] SEC_MR = 3'd5;

    function automatic logic [7:0] to_byte(input logic [VW-1:0] comp);
        logic [F+8:0] p;
        logic [8:0]   b;
        p = {comp, 8'b0} - (F+9)'(comp);
        b = p[F+8:F];
        return (b > 9'd255) ? 8'd255 : b[7:0];
    endfunction

    t_ctl               r3_ctl, r4_ctl, r5_ctl, r6_ctl, r7_ctl, r8_ctl;
    logic               r9_vld;
    logic [VW-1:0]      r3_w;
    logic [TW-1:0]      r4_t;
    logic [TW+HPW-1:0]  r4_prodh;
    logic [VW-1:0]      r4_w2;
    logic [HPW-1:0]     r5_hp;
    logic [VW-1:0]      r5_w4;
    logic [UW-1:0]      r6_u;
    logic [UW+F-1:0]    r6_prodl;
    logic [VW-1:0]      r6_onem;
    logic [2:0]         r6_sec;
    logic [VW-1:0]      r7_c;
    logic [VW-1:0]      r7_onem;
    logic [2:0]         r7_sec;
    logic [VW-1:0]      r8_c;
    logic [VW-1:0]      r8_xc;
    logic [2:0]         r8_sec;
    logic [7:0]         r_red, r_green, r_blue;

    logic [F+6:0]       t_full;
    logic [2*F+1:0]     sq1, sq2, xprod;
    logic [HPW-1:0]     hq;
    logic [F+6:0]       hr;
    logic [F+3:0]       u_full;
    logic [VW-1:0]      f, tdist;
    logic [F-1:0]       lq, lqc, lit;
    logic [UW-1:0]      l25, lr;
    logic [VW-1:0]      cr, cg, cb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_ctl <= '0;
            r4_ctl <= '0;
            r5_ctl <= '0;
            r6_ctl <= '0;
            r7_ctl <= '0;
            r8_ctl <= '0;
            r9_vld <= 1'b0;
        end else begin
            r3_ctl <= i_ctl;
            r4_ctl <= r3_ctl;
            r5_ctl <= r4_ctl;
            r6_ctl <= r5_ctl;
            r7_ctl <= r6_ctl;
            r8_ctl <= r7_ctl;
            r9_vld <= r8_ctl.valid;
        end
    end

    always_comb begin
        // hue: 62*w then reciprocal of 15 with one correction step
        t_full = {r3_w, 6'b0} - (F+7)'({r3_w, 1'b0});
        sq1    = r3_w * r3_w;
        hq     = r4_prodh[TW +: HPW];
        hr     = (F+7)'(r4_t) - ({hq, 4'b0} - (F+7)'(hq));
        sq2    = r4_w2 * r4_w2;
        // lightness: 7*w^4 then reciprocal of 25 with one correction step
        u_full = {r5_w4, 3'b0} - (F+4)'(r5_w4);
        f      = r5_hp[F:0];
        tdist  = (f >= ONE) ? f - ONE : ONE - f;
        lq     = r6_prodl[UW +: F];
        l25    = UW'({lq, 4'b0}) + UW'({lq, 3'b0}) + UW'(lq);
        lr     = r6_u - l25;
        lqc    = lq + {{(F-1){1'b0}}, (lr >= UW'(LIT_DIV))};
        lit    = HALF - lqc;
        xprod  = r7_c * r7_onem;
        // six-sector select; L <= 1/2 so the offset is zero
        case (r8_sec)
            SEC_RY:  begin cr = r8_c;  cg = r8_xc; cb = '0;    end
            SEC_YG:  begin cr = r8_xc; cg = r8_c;  cb = '0;    end
            SEC_GC:  begin cr = '0;    cg = r8_c;  cb = r8_xc; end
            SEC_CB:  begin cr = '0;    cg = r8_xc; cb = r8_c;  end
            SEC_BM:  begin cr = r8_xc; cg = '0;    cb = r8_c;  end
            SEC_MR:  begin cr = r8_c;  cg = '0;    cb = r8_xc; end
            default: begin cr = '0;    cg = '0;    cb = '0;    end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r3_w     <= ONE - i_q;
        r4_t     <= t_full[TW-1:0];
        r4_prodh <= t_full[TW-1:0] * HUE_RECIP;
        r4_w2    <= sq1[2*F:F];
        r5_hp    <= hq + {{(HPW-1){1'b0}}, (hr >= (F+7)'(HUE_DIV))};
        r5_w4    <= sq2[2*F:F];
        r6_u     <= u_full[UW-1:0];
        r6_prodl <= u_full[UW-1:0] * LIT_RECIP;
        r6_onem  <= ONE - tdist;
        r6_sec   <= r5_hp[HPW-1:F];
        r7_c     <= {lit, 1'b0};
        r7_onem  <= r6_onem;
        r7_sec   <= r6_sec;
        r8_c     <= r7_c;
        r8_xc    <= xprod[2*F:F];
        r8_sec   <= r7_sec;
        r_red    <= r8_ctl.has ? to_byte(cr) : 8'd0;
        r_green  <= r8_ctl.has ? to_byte(cg) : 8'd0;
        r_blue   <= r8_ctl.has ? to_byte(cb) : 8'd0;
    end

    assign o_valid = r9_vld;
    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;

    a_sector: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r5_ctl.valid |-> r5_hp < HP_LIMIT)
        else $error("hue sector beyond four");

endmodule

[tb/scalar_to_rainbow_rgb_unit_test.sv]
module scalar_to_rainbow_rgb_unit_test import scrgb_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC        = 16;
    localparam int LAT         = FRAC + 10;   // start to o_valid, as the block's own LAT
    localparam int STALL_LIMIT = 2000;        // cycles with no handshake of any kind
    localparam logic [63:0] UNIT = 64'd1 << FRAC;

    // indexes past the two real registers; writes to them must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    localparam logic signed [DATA_W-1:0] S_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] S_MAX = 32'sh7fff_ffff;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    // one entry of the driver's work list
    typedef enum logic [1:0] {OP_PIXEL, OP_REG_WRITE, OP_SETTLE} t_op_kind;

    typedef struct {
        t_op_kind                   kind;
        logic signed [DATA_W-1:0]   scalar;
        logic                       has;
        logic [CFG_IDX_W-1:0]       idx;
        logic [DATA_W-1:0]          data;
        bit                         idle_ok;
    } t_plan_op;

    // clock, reset and block ports; every input starts at a known value
    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     start = 1'b0;
    logic                     busy;
    logic signed [DATA_W-1:0] i_scalar_value = '0;
    logic                     i_has_value = 1'b0;
    logic                     o_valid;
    logic [7:0]               o_red;
    logic [7:0]               o_green;
    logic [7:0]               o_blue;
    logic                     i_cfg_valid = 1'b0;
    logic                     o_cfg_ready;
    logic [CFG_IDX_W-1:0]     i_cfg_index = '0;
    logic [DATA_W-1:0]        i_cfg_data = '0;

    // work list for the driver and colors still owed by the block
    t_plan_op drive_plan[$];
    t_rgb     color_due[$];

    // our own copy of the range registers
    logic signed [DATA_W-1:0] scale_lo = '0;
    logic signed [DATA_W-1:0] scale_hi = 32'sd65536;

    // handshakes seen at the last rising edge, read by the driver at the falling edge
    logic item_took = 1'b0;
    logic reg_took  = 1'b0;

    bit drv_active  = 1'b0;
    bit cur_idle_ok = 1'b0;
    int gap_left    = 0;
    int settle_cnt  = 0;
    int stall_cycles = 0;

    int fail_count  = 0;
    int mismatches  = 0;
    int items_in    = 0;
    int dark_in     = 0;
    int colors_seen = 0;
    int reg_writes  = 0;
    int phase_count = 0;

    scalar_to_rainbow_rgb_unit #(.FRAC_BITS(FRAC)) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_scalar_value (i_scalar_value),
        .i_has_value    (i_has_value),
        .o_valid        (o_valid),
        .o_red          (o_red),
        .o_green        (o_green),
        .o_blue         (o_blue),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Scale an 8-bit channel from a Q1.FRAC component, truncate, saturate at full.
    function automatic logic [7:0] channel_byte(logic [63:0] comp);
        logic [63:0] b;
        b = (64'd255 * comp) >> FRAC;
        return (b > 64'd255) ? 8'd255 : b[7:0];
    endfunction

    // Expected color of one pixel under the current range registers.
    function automatic t_rgb rainbow_color(logic signed [DATA_W-1:0] s, logic has);
        longint      x;
        longint      lo;
        longint      hi;
        logic [63:0] v;
        logic [63:0] w;
        logic [63:0] hue6;
        logic [63:0] sector;
        logic [63:0] w2;
        logic [63:0] w4;
        logic [63:0] lum;
        logic [63:0] chroma;
        logic [63:0] frac;
        logic [63:0] tdev;
        logic [63:0] xc;
        logic [63:0] r;
        logic [63:0] g;
        logic [63:0] b;
        t_rgb        res;

        res = '0;
        if (!has)
            return res;       // uncovered pixel: black

        x  = s;
        lo = scale_lo;
        hi = scale_hi;
        if (hi <= lo) begin
            v = '0;           // empty range sits at the blue end
        end else begin
            if (x > hi) x = hi;
            if (x < lo) x = lo;
            v = (64'(x - lo) << FRAC) / 64'(hi - lo);
            if (v > UNIT) v = UNIT;
        end

        w      = UNIT - v;
        hue6   = (64'd248 * w) / 64'd60;
        sector = hue6 >> FRAC;
        w2     = (w * w) >> FRAC;
        w4     = (w2 * w2) >> FRAC;
        lum    = (UNIT / 2) - (64'd28 * w4) / 64'd100;
        chroma = 2 * lum;
        frac   = hue6 & (2 * UNIT - 1);
        tdev   = (frac >= UNIT) ? frac - UNIT : UNIT - frac;
        xc     = (chroma * (UNIT - tdev)) >> FRAC;

        case (sector)
            64'd0:   begin r = chroma; g = xc;     b = '0;     end
            64'd1:   begin r = xc;     g = chroma; b = '0;     end
            64'd2:   begin r = '0;     g = chroma; b = xc;     end
            64'd3:   begin r = '0;     g = xc;     b = chroma; end
            64'd4:   begin r = xc;     g = '0;     b = chroma; end
            64'd5:   begin r = chroma; g = '0;     b = xc;     end
            default: begin r = '0;     g = '0;     b = '0;     end
        endcase

        res.red   = channel_byte(r);
        res.green = channel_byte(g);
        res.blue  = channel_byte(b);
        return res;
    endfunction

    // Mostly values inside the range, some at its ends, some just outside, some anything.
    function automatic logic signed [DATA_W-1:0] pick_scalar(logic signed [DATA_W-1:0] lo,
                                                             logic signed [DATA_W-1:0] hi);
        longint unsigned span;
        longint unsigned off;
        int unsigned     mode;

        mode = $urandom_range(0, 19);
        if (mode == 0 || hi <= lo)
            return $urandom;
        if (mode == 1)
            return lo;
        if (mode == 2)
            return hi;
        if (mode == 3)
            return lo - $urandom_range(1, 1000);
        if (mode == 4)
            return hi + $urandom_range(1, 1000);
        span = longint'(hi) - longint'(lo);
        off  = {$urandom, $urandom} % (span + 1);
        return 32'(longint'(lo) + longint'(off));
    endfunction

    task automatic add_pixel(logic signed [DATA_W-1:0] s, logic has, bit idle_ok);
        t_plan_op op;
        op = '{kind: OP_PIXEL, scalar: s, has: has, idx: '0, data: '0, idle_ok: idle_ok};
        drive_plan.push_back(op);
    endtask

    // Drain the pipeline first, then write; the block is idle for every register write.
    task automatic add_reg_write(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
        t_plan_op op;
        op = '{kind: OP_SETTLE, scalar: '0, has: 1'b0, idx: '0, data: '0, idle_ok: 1'b0};
        drive_plan.push_back(op);
        op = '{kind: OP_REG_WRITE, scalar: '0, has: 1'b0, idx: idx, data: data, idle_ok: 1'b0};
        drive_plan.push_back(op);
    endtask

    // Driver: change inputs at the falling edge only, one nonblocking write per signal.
    always @(negedge i_clk) begin
        logic     nx_start;
        logic     nx_cfg_valid;
        t_plan_op op;

        nx_start     = start;
        nx_cfg_valid = i_cfg_valid;
        if (i_rst_n) begin
            // retire whatever was taken at the last rising edge
            if (item_took) begin
                nx_start   = 1'b0;
                drv_active = 1'b0;
                if (cur_idle_ok && $urandom_range(0, 4) == 0)
                    gap_left = $urandom_range(1, 7);
            end
            if (reg_took) begin
                nx_cfg_valid = 1'b0;
                drv_active   = 1'b0;
            end

            if (!drv_active) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (drive_plan.size() > 0) begin
                    op = drive_plan[0];
                    case (op.kind)
                        OP_PIXEL: begin
                            void'(drive_plan.pop_front());
                            i_scalar_value <= op.scalar;
                            i_has_value    <= op.has;
                            nx_start       = 1'b1;
                            drv_active     = 1'b1;
                            cur_idle_ok    = op.idle_ok;
                        end
                        OP_REG_WRITE: begin
                            void'(drive_plan.pop_front());
                            i_cfg_index  <= op.idx;
                            i_cfg_data   <= op.data;
                            nx_cfg_valid = 1'b1;
                            drv_active   = 1'b1;
                        end
                        OP_SETTLE: begin
                            // hold until every color is back, then let the pipe go quiet
                            if (color_due.size() != 0) begin
                                settle_cnt = 0;
                            end else if (settle_cnt >= LAT + 4) begin
                                settle_cnt = 0;
                                void'(drive_plan.pop_front());
                            end else begin
                                settle_cnt++;
                            end
                        end
                        default: void'(drive_plan.pop_front());
                    endcase
                end
            end
        end
        start       <= nx_start;
        i_cfg_valid <= nx_cfg_valid;
    end

    // Monitor: sample at the rising edge, predict on acceptance, check each result.
    always @(posedge i_clk) begin
        t_rgb want;

        item_took <= start && !busy;
        reg_took  <= i_cfg_valid && o_cfg_ready;

        if (o_valid) begin
            colors_seen++;
            if (color_due.size() == 0) begin
                fail_count++;
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: color %0h/%0h/%0h with no pixel outstanding",
                             $realtime, o_red, o_green, o_blue);
            end else begin
                want = color_due.pop_front();
                if (o_red !== want.red || o_green !== want.green || o_blue !== want.blue) begin
                    fail_count++;
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: rgb expected %0d/%0d/%0d got %0d/%0d/%0d",
                                 $realtime, want.red, want.green, want.blue,
                                 o_red, o_green, o_blue);
                end
            end
        end

        // register writes only land while the pipe is empty, so update the copy at once
        if (i_cfg_valid && o_cfg_ready) begin
            reg_writes++;
            if (i_cfg_index == CFG_RANGE_LOW)
                scale_lo = i_cfg_data;
            else if (i_cfg_index == CFG_RANGE_HIGH)
                scale_hi = i_cfg_data;
        end

        if (start && !busy) begin
            color_due.push_back(rainbow_color(i_scalar_value, i_has_value));
            items_in++;
            if (!i_has_value)
                dark_in++;
        end
    end

    // Watchdog: end the run if no handshake of any kind happens for too long.
    always @(posedge i_clk) begin
        if ((start && !busy) || (i_cfg_valid && o_cfg_ready) || o_valid) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", stall_cycles);
            $display("FAIL scalar_to_rainbow_rgb_unit");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        logic signed [DATA_W-1:0] plan_lo;
        logic signed [DATA_W-1:0] plan_hi;
        longint                   wide_hi;
        bit                       idle_ok;
        int                       kind;

        // directed: reset range 0..1.0
        add_pixel(S_MAX, 1'b0, 1'b0);                // no value: black
        add_pixel('0, 1'b0, 1'b0);
        add_pixel(S_MIN, 1'b1, 1'b0);                // clamp below
        add_pixel(S_MAX, 1'b1, 1'b0);                // clamp above
        add_pixel(32'sd0, 1'b1, 1'b1);
        add_pixel(32'sd65536, 1'b1, 1'b1);
        add_pixel(32'sd1, 1'b1, 1'b1);
        add_pixel(32'sd65535, 1'b1, 1'b1);
        add_pixel(32'sd32768, 1'b1, 1'b1);
        // near each hue sector edge, then two points inside sectors
        add_pixel(32'sd49691, 1'b1, 1'b1);
        add_pixel(32'sd33825, 1'b1, 1'b1);
        add_pixel(32'sd17961, 1'b1, 1'b1);
        add_pixel(32'sd2114, 1'b1, 1'b1);
        add_pixel(32'sd8000, 1'b1, 1'b1);
        add_pixel(32'sd58000, 1'b1, 1'b1);

        // widest possible range
        add_reg_write(CFG_RANGE_LOW, S_MIN);
        add_reg_write(CFG_RANGE_HIGH, S_MAX);
        add_pixel(S_MIN, 1'b1, 1'b0);
        add_pixel(S_MAX, 1'b1, 1'b0);
        add_pixel(32'sd0, 1'b1, 1'b0);
        add_pixel(32'shc000_0000, 1'b1, 1'b0);

        // spare indexes must leave the range alone
        add_reg_write(CFG_SPARE_A, 32'h0000_0000);
        add_reg_write(CFG_SPARE_B, 32'hffff_ffff);
        add_pixel(32'sh4000_0000, 1'b1, 1'b0);

        // empty range: equal ends, then reversed ends
        add_reg_write(CFG_RANGE_LOW, 32'sd5);
        add_reg_write(CFG_RANGE_HIGH, 32'sd5);
        add_pixel(32'sd5, 1'b1, 1'b0);
        add_reg_write(CFG_RANGE_LOW, 32'sd65536);
        add_reg_write(CFG_RANGE_HIGH, -32'sd65536);
        add_pixel(32'sd0, 1'b1, 1'b0);
        add_pixel(S_MAX, 1'b1, 1'b0);

        // random phases, each under its own range setting
        for (int ph = 0; ph < 8; ph++) begin
            kind = (ph < 6) ? ph : $urandom_range(0, 5);
            case (kind)
                0: begin plan_lo = '0; plan_hi = 32'sd65536; end
                1: begin plan_lo = S_MIN; plan_hi = S_MAX; end
                2: begin
                    plan_lo = $urandom;
                    wide_hi = longint'(plan_lo) + $urandom_range(1, 1 << 20);
                    plan_hi = (wide_hi > longint'(S_MAX)) ? S_MAX : 32'(wide_hi);
                end
                3: begin plan_lo = $urandom; plan_hi = $urandom; end
                4: begin plan_lo = $urandom; plan_hi = plan_lo; end
                default: begin
                    plan_lo = -$urandom_range(0, 1 << 24);
                    plan_hi = $urandom_range(1, 1 << 30);
                end
            endcase
            add_reg_write(CFG_RANGE_LOW, plan_lo);
            add_reg_write(CFG_RANGE_HIGH, plan_hi);
            if ($urandom_range(0, 2) == 0)
                add_reg_write($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B, $urandom);
            phase_count++;

            idle_ok = 1'b1;
            for (int n = 0; n < 130; n++) begin
                // idle in stretches; the last phase runs back to back
                if (n % 40 == 0)
                    idle_ok = ($urandom_range(0, 3) != 0);
                add_pixel(pick_scalar(plan_lo, plan_hi), ($urandom_range(0, 7) != 0),
                          idle_ok && (ph != 7));
            end
        end

        // reset sequence
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // wait for the work list to run dry and every color to come back
        do
            @(posedge i_clk);
        while (drive_plan.size() != 0 || drv_active || color_due.size() != 0);
        repeat (LAT + 10) @(posedge i_clk);

        if (color_due.size() != 0) begin
            fail_count++;
            $display("%0d colors never arrived", color_due.size());
        end

        $display("covered %0d pixels (%0d without value), %0d colors back, %0d mismatches",
                 items_in, dark_in, colors_seen, mismatches);
        $display("ran %0d random range settings with %0d register writes",
                 phase_count, reg_writes);
        if (fail_count == 0)
            $display("PASS scalar_to_rainbow_rgb_unit");
        else
            $display("FAIL scalar_to_rainbow_rgb_unit");
        $finish;
    end

endmodule
